@@ design/cabc_pkg.sv @@
`default_nettype none

package cabc_pkg;

    // Limits on the cursor image and on the framebuffer.
    localparam int CURSOR_MAX_DIM = 256;
    localparam int SCREEN_MAX_DIM = 8192;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SCREEN_WIDTH  = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_MODE_32BPP    = 3'd4,
        REG_CURSOR_ENABLE = 3'd5
    } reg_index_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic signed [13:0] origin_x;
        logic signed [13:0] origin_y;
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
        logic               mode_32bpp;
        logic               cursor_enable;
    } cfg_t;

    // Alpha value of a fully opaque pixel.
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    // Top byte of the output word in 32-bit mode.
    localparam logic [7:0] TOP_BYTE_32 = 8'hFF;

endpackage

`default_nettype wire

@@ design/cursor_alpha_blend_clip_core.sv @@
// Cursor overlay blender with screen clipping.
//
// Input channel: an item (one cursor pixel with its position inside the
// cursor image, its RGBA value and the background pixel under it) is taken
// at a rising edge where start is high and busy is low. busy stays low, so
// one item can be taken in every cycle.
// Result channel: done is high for exactly one cycle per item, carrying
// write_pixel, screen_col, screen_row and out_color. When write_pixel is
// low the other fields are zero. The receiver cannot stall this channel.
// An item passes through the input register stage and then the result
// register stage. Throughput is one item per cycle, set by the single
// blend stage between the input and result registers.
// Configuration: cfg_we writes cfg_data into register cfg_index at the
// edge; write only while no item is in flight.
// Reset: rst_n clears the pipeline and restores the register defaults
// (origin 0, screen size 0, 32-bit mode, cursor disabled).
`default_nettype none

module cursor_alpha_blend_clip_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [13:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  cursor_col,
    input  wire logic [7:0]  cursor_row,
    input  wire logic [7:0]  fg_red,
    input  wire logic [7:0]  fg_green,
    input  wire logic [7:0]  fg_blue,
    input  wire logic [7:0]  fg_alpha,
    input  wire logic [31:0] background,
    output logic             done,
    output logic             write_pixel,
    output logic [12:0]      screen_col,
    output logic [12:0]      screen_row,
    output logic [31:0]      out_color
);

    cabc_pkg::cfg_t cfg;

    logic        in_valid_reg;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [31:0] bg_reg;

    logic        write_next;
    logic [12:0] col_next;
    logic [12:0] row_next;
    logic [31:0] color_next;

    logic        done_reg;
    logic        write_reg;
    logic [12:0] scol_reg;
    logic [12:0] srow_reg;
    logic [31:0] color_reg;

    logic        accept;
    logic        wr_pix;
    logic [12:0] sx;
    logic [12:0] sy;
    logic [31:0] blended;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cabc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg   <= cursor_col;
            row_reg   <= cursor_row;
            red_reg   <= fg_red;
            green_reg <= fg_green;
            blue_reg  <= fg_blue;
            alpha_reg <= fg_alpha;
            bg_reg    <= background;
        end
    end

    cabc_clip u_clip (
        .cfg         (cfg),
        .cursor_col  (col_reg),
        .cursor_row  (row_reg),
        .fg_alpha    (alpha_reg),
        .write_pixel (wr_pix),
        .screen_col  (sx),
        .screen_row  (sy)
    );

    cabc_blend u_blend (
        .fg_red     (red_reg),
        .fg_green   (green_reg),
        .fg_blue    (blue_reg),
        .fg_alpha   (alpha_reg),
        .background (bg_reg),
        .mode_32bpp (cfg.mode_32bpp),
        .color      (blended)
    );

    // Fields are forced to zero when no write is made.
    assign write_next = wr_pix;
    assign col_next   = wr_pix ? sx : 13'd0;
    assign row_next   = wr_pix ? sy : 13'd0;
    assign color_next = wr_pix ? blended : 32'd0;

    // Result register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            write_reg <= write_next;
            scol_reg  <= col_next;
            srow_reg  <= row_next;
            color_reg <= color_next;
        end
    end

    assign done        = done_reg;
    assign write_pixel = write_reg;
    assign screen_col  = scol_reg;
    assign screen_row  = srow_reg;
    assign out_color   = color_reg;

endmodule

`default_nettype wire

@@ design/cabc_cfg.sv @@
`default_nettype none

module cabc_cfg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [13:0]        cfg_data,
    output cabc_pkg::cfg_t          cfg
);

    cabc_pkg::cfg_t cfg_reg;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.screen_width  <= '0;
            cfg_reg.screen_height <= '0;
            cfg_reg.mode_32bpp    <= 1'b1;
            cfg_reg.cursor_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cabc_pkg::REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data;
                cabc_pkg::REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data;
                cabc_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[12:0];
                cabc_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[12:0];
                cabc_pkg::REG_MODE_32BPP:    cfg_reg.mode_32bpp    <= cfg_data[0];
                cabc_pkg::REG_CURSOR_ENABLE: cfg_reg.cursor_enable <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/cabc_clip.sv @@
`default_nettype none

module cabc_clip (
    input  wire cabc_pkg::cfg_t     cfg,
    input  wire logic [7:0]         cursor_col,
    input  wire logic [7:0]         cursor_row,
    input  wire logic [7:0]         fg_alpha,
    output logic                    write_pixel,
    output logic [12:0]             screen_col,
    output logic [12:0]             screen_row
);

    localparam logic [8:0]  CURSOR_LIM = 9'(cabc_pkg::CURSOR_MAX_DIM);
    localparam logic [14:0] SCREEN_LIM = 15'(cabc_pkg::SCREEN_MAX_DIM);

    logic signed [14:0] sx;
    logic signed [14:0] sy;
    logic [14:0]        wlim;
    logic [14:0]        hlim;
    logic               in_cursor;
    logic               in_screen;

    // Screen position is the origin plus the position inside the cursor.
    assign sx = 15'(cfg.origin_x) + $signed({7'd0, cursor_col});
    assign sy = 15'(cfg.origin_y) + $signed({7'd0, cursor_row});

    // Clip bounds are the register values, capped at the screen limit.
    assign wlim = ({2'b00, cfg.screen_width} < SCREEN_LIM) ?
                  {2'b00, cfg.screen_width} : SCREEN_LIM;
    assign hlim = ({2'b00, cfg.screen_height} < SCREEN_LIM) ?
                  {2'b00, cfg.screen_height} : SCREEN_LIM;

    assign in_cursor = ({1'b0, cursor_col} < CURSOR_LIM) &&
                       ({1'b0, cursor_row} < CURSOR_LIM);

    // A negative position fails on its sign bit before the compare.
    assign in_screen = !sx[14] && !sy[14] &&
                       ($unsigned(sx) < wlim) && ($unsigned(sy) < hlim);

    assign write_pixel = cfg.cursor_enable && in_cursor && in_screen &&
                         (fg_alpha != 8'd0);
    assign screen_col  = sx[12:0];
    assign screen_row  = sy[12:0];

endmodule

`default_nettype wire

@@ design/cabc_blend.sv @@
`default_nettype none

module cabc_blend (
    input  wire logic [7:0]         fg_red,
    input  wire logic [7:0]         fg_green,
    input  wire logic [7:0]         fg_blue,
    input  wire logic [7:0]         fg_alpha,
    input  wire logic [31:0]        background,
    input  wire logic               mode_32bpp,
    output logic [31:0]             color
);

    // Exact quotient by 255 for any 16-bit value up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                       input logic [7:0] a);
        logic [15:0] pf;
        logic [15:0] pb;
        pf = {8'd0, fg} * {8'd0, a};
        pb = {8'd0, bg} * (16'd255 - {8'd0, a});
        return div255(pf + pb);
    endfunction

    logic       opaque;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;

    // Opaque pixels pass unchanged; others are mixed per channel.
    assign opaque = (fg_alpha == cabc_pkg::ALPHA_OPAQUE);
    assign r = opaque ? fg_red   : mix(fg_red,   background[23:16], fg_alpha);
    assign g = opaque ? fg_green : mix(fg_green, background[15:8],  fg_alpha);
    assign b = opaque ? fg_blue  : mix(fg_blue,  background[7:0],   fg_alpha);

    assign color = {(mode_32bpp ? cabc_pkg::TOP_BYTE_32 : 8'h00), r, g, b};

endmodule

`default_nettype wire

@@ design/cabc_checker.sv @@
`default_nettype none

module cabc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [7:0]  fg_alpha,
    input wire logic        done,
    input wire logic        write_pixel,
    input wire logic [12:0] screen_col,
    input wire logic [12:0] screen_row,
    input wire logic [31:0] out_color
);

    // Every result comes from an item taken through the input and result registers.
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an item two cycles before");

    // A result without a write carries all-zero fields.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_pixel) |->
            (screen_col == 13'd0 && screen_row == 13'd0 && out_color == 32'd0))
        else $error("non-zero fields on a suppressed write");

    // A fully transparent pixel is never written.
    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && write_pixel) |-> ($past(fg_alpha, 2) != 8'd0))
        else $error("transparent pixel written");

    // The top byte is either 0xFF or zero.
    a_top_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (done && write_pixel) |->
            (out_color[31:24] == 8'hFF || out_color[31:24] == 8'h00))
        else $error("bad top byte");

endmodule

bind cursor_alpha_blend_clip_core cabc_checker u_cabc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .fg_alpha    (fg_alpha),
    .done        (done),
    .write_pixel (write_pixel),
    .screen_col  (screen_col),
    .screen_row  (screen_row),
    .out_color   (out_color)
);

`default_nettype wire
